### rtl/lvss_pkg.sv
`default_nettype none
package lvss_pkg;

    localparam int FRACTION_BITS = 4;

    localparam int LANE_W   = 2;
    localparam int POS_W    = 17;
    localparam int OFFSET_W = 10;
    localparam int VEL_W    = 11;
    localparam int TGT_W    = 11;
    localparam int GAP_W    = 13;
    localparam int SPD_W    = 10;
    localparam int LW_W     = 8;
    localparam int CFG_W    = 10;
    localparam int CFG_IDX_W = 1;

    localparam int SQ_W     = 2 * VEL_W;
    localparam int ROOT_W   = SQ_W / 2;
    localparam int REM_W    = ROOT_W + 3;
    localparam int STEP_W   = $clog2(ROOT_W);
    localparam int CTR_W    = LW_W + LANE_W;
    localparam int WIN_W    = CTR_W + 2;

    localparam logic [GAP_W-1:0] CLEAR_ROAD_GAP = GAP_W'(300 << FRACTION_BITS);
    localparam logic [GAP_W-1:0] NEAR_GAP       = GAP_W'(30 << FRACTION_BITS);
    localparam logic [GAP_W-1:0] CLOSE_GAP      = GAP_W'(20 << FRACTION_BITS);
    localparam logic [TGT_W-1:0] BACKOFF_SPEED  = TGT_W'(3 << FRACTION_BITS);
    localparam logic [WIN_W-1:0] HALF_WINDOW    = WIN_W'(2 << FRACTION_BITS);
    localparam logic [SPD_W-1:0] SPEED_MAX      = '1;

    localparam logic [SPD_W-1:0] TARGET_SPEED_RST = SPD_W'(348);
    localparam logic [LW_W-1:0]  LANE_WIDTH_RST   = LW_W'(64);

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SPEED = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LANE_WIDTH   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SUM,
        ST_ROOT,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic load;
        logic square;
        logic sum;
        logic root_step;
        logic update;
    } dp_cmd_t;

    typedef struct packed {
        logic root_last;
        logic final_item;
    } dp_status_t;

endpackage
`default_nettype wire

### rtl/lvss_vehicle_if.sv
`default_nettype none
interface lvss_vehicle_if;
    import lvss_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [LANE_W-1:0]          lane_index;
    logic [POS_W-1:0]           ego_position;
    logic signed [OFFSET_W-1:0] other_offset;
    logic signed [VEL_W-1:0]    other_vel_x;
    logic signed [VEL_W-1:0]    other_vel_y;
    logic [POS_W-1:0]           other_position;
    logic                       final_item;

    modport source (
        output valid, lane_index, ego_position, other_offset, other_vel_x,
               other_vel_y, other_position, final_item,
        input  ready
    );

    modport sink (
        input  valid, lane_index, ego_position, other_offset, other_vel_x,
               other_vel_y, other_position, final_item,
        output ready
    );
endinterface
`default_nettype wire

### rtl/lvss_result_if.sv
`default_nettype none
interface lvss_result_if;
    import lvss_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [TGT_W-1:0] speed_target;
    logic [GAP_W-1:0]        gap_ahead;
    logic [SPD_W-1:0]        lead_speed;

    modport source (
        output valid, speed_target, gap_ahead, lead_speed,
        input  ready
    );

    modport sink (
        input  valid, speed_target, gap_ahead, lead_speed,
        output ready
    );
endinterface
`default_nettype wire

### rtl/lvss_ctrl.sv
`default_nettype none
module lvss_ctrl
    import lvss_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;
    logic   emit;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_SQUARE;
            end
            ST_SQUARE: state_next = ST_SUM;
            ST_SUM:    state_next = ST_ROOT;
            ST_ROOT:
            begin
                if (status.root_last)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (!status.final_item || slot_free)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        emit = 1'b0;
        unique case (state_reg)
            ST_IDLE:   cmd.load = in_valid;
            ST_SQUARE: cmd.square = 1'b1;
            ST_SUM:    cmd.sum = 1'b1;
            ST_ROOT:   cmd.root_step = 1'b1;
            ST_UPDATE:
            begin
                cmd.update = !status.final_item || slot_free;
                emit       = status.final_item && slot_free;
            end
            default:   cmd = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_ready)
            out_valid_next = 1'b0;
        if (emit)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

### rtl/lvss_dp.sv
`default_nettype none
module lvss_dp
    import lvss_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire dp_cmd_t                    cmd,
    output dp_status_t                      status,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [CFG_W-1:0]           cfg_data,
    input  wire logic [LANE_W-1:0]          lane_index,
    input  wire logic [POS_W-1:0]           ego_position,
    input  wire logic signed [OFFSET_W-1:0] other_offset,
    input  wire logic signed [VEL_W-1:0]    other_vel_x,
    input  wire logic signed [VEL_W-1:0]    other_vel_y,
    input  wire logic [POS_W-1:0]           other_position,
    input  wire logic                       final_item,
    output logic signed [TGT_W-1:0]         speed_target,
    output logic [GAP_W-1:0]                gap_ahead,
    output logic [SPD_W-1:0]                lead_speed
);

    // configuration and running minimum (control-like, reset)
    logic [SPD_W-1:0] target_speed_reg;
    logic [LW_W-1:0]  lane_width_reg;
    logic [GAP_W-1:0] min_gap_reg, min_gap_next;
    logic [SPD_W-1:0] min_spd_reg, min_spd_next;

    // captured item
    logic [LANE_W-1:0]          lane_reg;
    logic [POS_W-1:0]           ego_reg;
    logic [POS_W-1:0]           pos_reg;
    logic signed [OFFSET_W-1:0] d_reg;
    logic signed [VEL_W-1:0]    vx_reg;
    logic signed [VEL_W-1:0]    vy_reg;
    logic                       final_reg;

    logic [SQ_W-1:0]   sqx_reg, sqy_reg;
    logic              hit_reg;
    logic [POS_W-1:0]  gap_reg;
    logic [SQ_W-1:0]   n_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [STEP_W-1:0] step_reg;

    logic signed [TGT_W-1:0] tgt_out_reg;
    logic [GAP_W-1:0]        gap_out_reg;
    logic [SPD_W-1:0]        spd_out_reg;

    // lane window
    logic [CTR_W-1:0]        center;
    logic signed [WIN_W-1:0] center_s, win_lo, win_hi, d_ext;
    logic                    in_window, ahead;

    assign center   = CTR_W'(lane_width_reg * lane_reg) + CTR_W'(lane_width_reg >> 1);
    assign center_s = signed'(WIN_W'(center));
    assign win_lo   = center_s - signed'(HALF_WINDOW);
    assign win_hi   = center_s + signed'(HALF_WINDOW);
    assign d_ext    = WIN_W'(d_reg);
    assign in_window = (d_ext > win_lo) && (d_ext < win_hi);
    assign ahead     = pos_reg > ego_reg;

    // one result bit per step, two radicand bits consumed per step
    logic [REM_W+1:0] rem_shift, trial;
    logic             take;

    assign rem_shift = {rem_reg, n_reg[SQ_W-1 -: 2]};
    assign trial     = (REM_W+2)'({root_reg, 2'b01});
    assign take      = rem_shift >= trial;

    // running minimum update
    logic [SPD_W-1:0] spd_sat;

    assign spd_sat = (root_reg > ROOT_W'(SPEED_MAX)) ? SPEED_MAX : root_reg[SPD_W-1:0];

    always_comb
    begin
        min_gap_next = min_gap_reg;
        min_spd_next = min_spd_reg;
        if (hit_reg)
        begin
            if (gap_reg < POS_W'(min_gap_reg))
                min_gap_next = gap_reg[GAP_W-1:0];
            if (spd_sat < min_spd_reg)
                min_spd_next = spd_sat;
        end
    end

    logic signed [TGT_W-1:0] tgt_calc;

    always_comb
    begin
        priority if (min_gap_next < CLOSE_GAP)
            tgt_calc = signed'(TGT_W'(min_spd_next)) - signed'(BACKOFF_SPEED);
        else if (min_gap_next < NEAR_GAP)
            tgt_calc = signed'(TGT_W'(min_spd_next));
        else
            tgt_calc = signed'(TGT_W'(target_speed_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_speed_reg <= TARGET_SPEED_RST;
            lane_width_reg   <= LANE_WIDTH_RST;
            min_gap_reg      <= CLEAR_ROAD_GAP;
            min_spd_reg      <= TARGET_SPEED_RST;
            step_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_TARGET_SPEED:
                    begin
                        target_speed_reg <= cfg_data[SPD_W-1:0];
                        min_spd_reg      <= cfg_data[SPD_W-1:0];
                    end
                    CFG_LANE_WIDTH:   lane_width_reg <= cfg_data[LW_W-1:0];
                    default:          ;
                endcase
            end
            if (cmd.sum)
                step_reg <= STEP_W'(ROOT_W - 1);
            else if (cmd.root_step)
                step_reg <= step_reg - 1'b1;
            if (cmd.update)
            begin
                if (final_reg)
                begin
                    min_gap_reg <= CLEAR_ROAD_GAP;
                    min_spd_reg <= target_speed_reg;
                end
                else
                begin
                    min_gap_reg <= min_gap_next;
                    min_spd_reg <= min_spd_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            lane_reg  <= lane_index;
            ego_reg   <= ego_position;
            pos_reg   <= other_position;
            d_reg     <= other_offset;
            vx_reg    <= other_vel_x;
            vy_reg    <= other_vel_y;
            final_reg <= final_item;
        end
        if (cmd.square)
        begin
            sqx_reg <= SQ_W'(vx_reg * vx_reg);
            sqy_reg <= SQ_W'(vy_reg * vy_reg);
            hit_reg <= in_window && ahead;
            gap_reg <= pos_reg - ego_reg;
        end
        if (cmd.sum)
        begin
            n_reg    <= sqx_reg + sqy_reg;
            root_reg <= '0;
            rem_reg  <= '0;
        end
        if (cmd.root_step)
        begin
            n_reg <= n_reg << 2;
            if (take)
            begin
                rem_reg  <= REM_W'(rem_shift - trial);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_shift[REM_W-1:0];
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
        if (cmd.update && final_reg)
        begin
            tgt_out_reg <= tgt_calc;
            gap_out_reg <= min_gap_next;
            spd_out_reg <= min_spd_next;
        end
    end

    assign status.root_last  = (step_reg == '0);
    assign status.final_item = final_reg;

    assign speed_target = tgt_out_reg;
    assign gap_ahead    = gap_out_reg;
    assign lead_speed   = spd_out_reg;

endmodule
`default_nettype wire

### rtl/lead_vehicle_speed_selector.sv
`default_nettype none
// Lead vehicle speed selector. One tracked vehicle per vehicle transaction; vehicles
// inside the evaluated lane window (center +-2 m) and ahead of the ego update the
// smallest gap and lowest speed magnitude. The transaction flagged final_item yields one
// result transaction (speed target, gap, lead speed) and restarts the list. Each vehicle
// passes capture, square, sum, an 11-bit bit-serial square root and update in turn, and
// no new vehicle is taken before that update step. A result waits in an output register
// while the next list is accepted; a final vehicle holds its update step only while an
// earlier result has not yet been taken. Writing target_speed also reloads the running
// lead speed; the user sees that configuration is written between lists (not enforced).
module lead_vehicle_speed_selector
    import lvss_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    lvss_vehicle_if.sink              vehicle,
    lvss_result_if.source             result,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    lvss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vehicle.valid),
        .in_ready  (vehicle.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    lvss_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .lane_index     (vehicle.lane_index),
        .ego_position   (vehicle.ego_position),
        .other_offset   (vehicle.other_offset),
        .other_vel_x    (vehicle.other_vel_x),
        .other_vel_y    (vehicle.other_vel_y),
        .other_position (vehicle.other_position),
        .final_item     (vehicle.final_item),
        .speed_target   (result.speed_target),
        .gap_ahead      (result.gap_ahead),
        .lead_speed     (result.lead_speed)
    );

endmodule
`default_nettype wire
